[design/wsak_pkg.sv]
// ----------------------------------------------------------------------------
// wsak_pkg
// Types, constants and lookup functions shared by the accept-key generator.
// ----------------------------------------------------------------------------
package wsak_pkg;

    // Default limit on the hashed message length in bytes.
    localparam int MAX_MESSAGE_BYTES_DEF = 1023;
    // Length of the fixed GUID that follows the key.
    localparam int GUID_BYTES = 36;
    // Reset value of the output capacity register.
    localparam logic [6:0] CAP_RESET = 7'd29;
    // Depths of the internal queues.
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    // Number of base64 characters in a full accept value.
    localparam int B64_CHARS = 28;

    // One input item.
    typedef struct packed {
        logic [7:0] key_byte;
        logic       key_last;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       last;
        logic       error;
    } t_out_item;

    // One entry of the queue between the front and the hash engine.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       fin;
    } t_mid_item;

    typedef enum logic {
        FR_KEY,
        FR_GUID
    } t_front_state;

    typedef enum logic [2:0] {
        BK_DATA,
        BK_PAD,
        BK_LEN,
        BK_ROUND,
        BK_ADD,
        BK_OUT
    } t_back_state;

    localparam logic [31:0] SHA_IV0 = 32'h67452301;
    localparam logic [31:0] SHA_IV1 = 32'hEFCDAB89;
    localparam logic [31:0] SHA_IV2 = 32'h98BADCFE;
    localparam logic [31:0] SHA_IV3 = 32'h10325476;
    localparam logic [31:0] SHA_IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] SHA_K0 = 32'h5A827999;
    localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_CHAR  = 8'h3D;
    localparam logic [7:0] PAD_FIRST = 8'h80;

    localparam logic [8*GUID_BYTES-1:0] GUID_TEXT =
        "258EAFA5-E914-47DA-95CA-C5AB0DC85B11";

    // Byte of the GUID at a given position, first character at position 0.
    function automatic logic [7:0] guid_byte(input logic [5:0] idx);
        logic [8*GUID_BYTES-1:0] sh;
        sh = GUID_TEXT << {idx, 3'b000};
        return sh[8*GUID_BYTES-1 -: 8];
    endfunction

    // Base64 alphabet lookup.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

[design/wsak_fifo.sv]
// ----------------------------------------------------------------------------
// wsak_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
module wsak_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

[design/wsak_front.sv]
// ----------------------------------------------------------------------------
// wsak_front
// Accepts key bytes, drops a zero byte and the bytes after it, and appends
// the GUID and a finish marker when the last byte of a key arrives.
// ----------------------------------------------------------------------------
module wsak_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wsak_pkg::t_in_item  i_item,
    output logic                o_full,
    output logic                o_mid_push,
    output wsak_pkg::t_mid_item o_mid_item,
    input  logic                i_mid_full
);
    wsak_pkg::t_front_state r_state, n_state;
    logic [5:0]             r_idx, n_idx;
    logic                   r_ended, n_ended;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsak_pkg::FR_KEY;
            r_idx   <= '0;
            r_ended <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_ended <= n_ended;
        end
    end

    assign o_full = (r_state != wsak_pkg::FR_KEY) || i_mid_full;

    // Classify key bytes and feed the GUID after the last one.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_ended    = r_ended;
        o_mid_push = 1'b0;
        o_mid_item = '0;
        unique case (r_state)
            wsak_pkg::FR_KEY: begin
                if (i_push && !i_mid_full) begin
                    if (!r_ended) begin
                        if (i_item.key_byte == 8'd0) begin
                            n_ended = 1'b1;
                        end else begin
                            o_mid_push          = 1'b1;
                            o_mid_item.byte_val = i_item.key_byte;
                        end
                    end
                    if (i_item.key_last) begin
                        n_ended = 1'b0;
                        n_idx   = '0;
                        n_state = wsak_pkg::FR_GUID;
                    end
                end
            end
            wsak_pkg::FR_GUID: begin
                if (!i_mid_full) begin
                    o_mid_push = 1'b1;
                    if (r_idx == 6'(wsak_pkg::GUID_BYTES)) begin
                        o_mid_item.fin = 1'b1;
                        n_state        = wsak_pkg::FR_KEY;
                    end else begin
                        o_mid_item.byte_val = wsak_pkg::guid_byte(r_idx);
                        n_idx               = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = wsak_pkg::FR_KEY;
        endcase
    end

endmodule

[design/wsak_back.sv]
// ----------------------------------------------------------------------------
// wsak_back
// Packs message bytes into blocks, runs SHA-1 one round per cycle, pads the
// message, emits base64 digest characters one per cycle when not stalled.
// ----------------------------------------------------------------------------
module wsak_back #(
    parameter int MAX_MESSAGE_BYTES = wsak_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_wdata,
    input  wsak_pkg::t_mid_item i_mid_item,
    input  logic                i_mid_empty,
    output logic                o_mid_pop,
    output logic                o_out_push,
    output wsak_pkg::t_out_item o_out_item,
    input  logic                i_out_full
);
    localparam logic [9:0] MAXB = 10'(MAX_MESSAGE_BYTES);
    localparam int DIGW = 8 * 21;

    wsak_pkg::t_back_state r_state, n_state;
    wsak_pkg::t_back_state r_ret, n_ret;
    logic [6:0]  r_cap;
    logic [9:0]  r_count, n_count;
    logic [5:0]  r_pos, n_pos;
    logic        r_first, n_first;
    logic [2:0]  r_lidx, n_lidx;
    logic [6:0]  r_round, n_round;
    logic [4:0]  r_k, n_k;
    logic [2:0]  r_nq, n_nq;
    logic [31:0] r_h [5];
    logic [31:0] n_h [5];

    logic [23:0]  r_acc, n_acc;
    logic [31:0]  r_w [16];
    logic [31:0]  n_w [16];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [31:0]  n_a, n_b, n_c, n_d, n_e;
    logic [DIGW-1:0] r_dig, n_dig;

    logic        put_en;
    logic [7:0]  put_byte;
    logic [63:0] len_vec;
    logic [63:0] len_sh;
    logic [31:0] f_val, k_val, w_new, tmp;
    logic [31:0] sum0, sum1, sum2, sum3, sum4;
    logic [6:0]  cap_m5;
    logic [4:0]  k_last;
    logic        cap_err;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= wsak_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Control and chaining state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsak_pkg::BK_DATA;
            r_ret   <= wsak_pkg::BK_DATA;
            r_count <= '0;
            r_pos   <= '0;
            r_first <= 1'b0;
            r_lidx  <= '0;
            r_round <= '0;
            r_k     <= '0;
            r_nq    <= '0;
            r_h[0]  <= wsak_pkg::SHA_IV0;
            r_h[1]  <= wsak_pkg::SHA_IV1;
            r_h[2]  <= wsak_pkg::SHA_IV2;
            r_h[3]  <= wsak_pkg::SHA_IV3;
            r_h[4]  <= wsak_pkg::SHA_IV4;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_first <= n_first;
            r_lidx  <= n_lidx;
            r_round <= n_round;
            r_k     <= n_k;
            r_nq    <= n_nq;
            r_h     <= n_h;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_w   <= n_w;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
        r_dig <= n_dig;
    end

    // Round function, message schedule and final additions.
    always_comb begin
        if (r_round < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = wsak_pkg::SHA_K0;
        end else if (r_round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = wsak_pkg::SHA_K1;
        end else if (r_round < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = wsak_pkg::SHA_K2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = wsak_pkg::SHA_K3;
        end
        w_new = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_new = {w_new[30:0], w_new[31]};
        tmp   = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];
        sum0  = r_h[0] + r_a;
        sum1  = r_h[1] + r_b;
        sum2  = r_h[2] + r_c;
        sum3  = r_h[3] + r_d;
        sum4  = r_h[4] + r_e;
    end

    // Capacity check inputs, error flag, last character index and length field.
    always_comb begin
        cap_m5  = r_cap - 7'd5;
        cap_err = (r_cap <= 7'd29);
        k_last  = {r_nq, 2'b00} - 5'd1;
        len_vec = {51'd0, r_count, 3'b000};
        len_sh  = len_vec << {r_lidx, 3'b000};
    end

    // Sequencer for the hash engine and the encoder.
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_count    = r_count;
        n_pos      = r_pos;
        n_first    = r_first;
        n_lidx     = r_lidx;
        n_round    = r_round;
        n_k        = r_k;
        n_nq       = r_nq;
        n_h        = r_h;
        n_acc      = r_acc;
        n_w        = r_w;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        n_d        = r_d;
        n_e        = r_e;
        n_dig      = r_dig;
        put_en     = 1'b0;
        put_byte   = '0;
        o_mid_pop  = 1'b0;
        o_out_push = 1'b0;
        o_out_item = '0;

        unique case (r_state)
            // Take message bytes, dropping those past the length limit.
            wsak_pkg::BK_DATA: begin
                if (!i_mid_empty) begin
                    o_mid_pop = 1'b1;
                    if (i_mid_item.fin) begin
                        n_state = wsak_pkg::BK_PAD;
                        n_first = 1'b1;
                    end else if (r_count < MAXB) begin
                        put_en   = 1'b1;
                        put_byte = i_mid_item.byte_val;
                        n_count  = r_count + 1'b1;
                    end
                end
            end
            // Padding: one marker byte, then zeros up to the length field.
            wsak_pkg::BK_PAD: begin
                if (r_first) begin
                    put_en   = 1'b1;
                    put_byte = wsak_pkg::PAD_FIRST;
                    n_first  = 1'b0;
                end else if (r_pos == 6'd56) begin
                    n_state = wsak_pkg::BK_LEN;
                    n_lidx  = '0;
                end else begin
                    put_en = 1'b1;
                end
            end
            // Message length in bits, big endian.
            wsak_pkg::BK_LEN: begin
                put_en   = 1'b1;
                put_byte = len_sh[63:56];
                n_lidx   = r_lidx + 1'b1;
            end
            // One compression round per cycle.
            wsak_pkg::BK_ROUND: begin
                n_e = r_d;
                n_d = r_c;
                n_c = {r_b[1:0], r_b[31:2]};
                n_b = r_a;
                n_a = tmp;
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[15] = w_new;
                n_round = r_round + 1'b1;
                if (r_round == 7'd79) begin
                    n_state = wsak_pkg::BK_ADD;
                end
            end
            // Fold the block result into the chaining values.
            wsak_pkg::BK_ADD: begin
                n_h[0]  = sum0;
                n_h[1]  = sum1;
                n_h[2]  = sum2;
                n_h[3]  = sum3;
                n_h[4]  = sum4;
                n_state = r_ret;
                if (r_ret == wsak_pkg::BK_OUT) begin
                    n_dig = {sum0, sum1, sum2, sum3, sum4, 8'd0};
                    n_k   = '0;
                    if (r_cap < 7'd5) begin
                        n_nq = '0;
                    end else if (cap_m5[6:2] >= 5'd6) begin
                        n_nq = 3'd7;
                    end else begin
                        n_nq = cap_m5[4:2] + 3'd1;
                    end
                end
            end
            // Encode the digest one character per cycle while the output queue has room.
            wsak_pkg::BK_OUT: begin
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    if (r_nq == 3'd0) begin
                        o_out_item.last  = 1'b1;
                        o_out_item.error = 1'b1;
                    end else begin
                        o_out_item.char_valid = 1'b1;
                        o_out_item.out_char   = (r_k == 5'(wsak_pkg::B64_CHARS - 1)) ?
                            wsak_pkg::PAD_CHAR : wsak_pkg::b64_char(r_dig[DIGW-1 -: 6]);
                        o_out_item.last       = (r_k == k_last);
                        o_out_item.error      = (r_k == k_last) && cap_err;
                        n_dig = r_dig << 6;
                        n_k   = r_k + 1'b1;
                    end
                    if (r_nq == 3'd0 || r_k == k_last) begin
                        n_state = wsak_pkg::BK_DATA;
                        n_count = '0;
                        n_pos   = '0;
                        n_h[0]  = wsak_pkg::SHA_IV0;
                        n_h[1]  = wsak_pkg::SHA_IV1;
                        n_h[2]  = wsak_pkg::SHA_IV2;
                        n_h[3]  = wsak_pkg::SHA_IV3;
                        n_h[4]  = wsak_pkg::SHA_IV4;
                    end
                end
            end
            default: n_state = wsak_pkg::BK_DATA;
        endcase

        // Byte packing; a full block starts the compression rounds.
        if (put_en) begin
            n_acc = {r_acc[15:0], put_byte};
            n_pos = r_pos + 1'b1;
            if (r_pos[1:0] == 2'd3) begin
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[15] = {r_acc, put_byte};
            end
            if (r_pos == 6'd63) begin
                n_ret   = (r_state == wsak_pkg::BK_LEN) ? wsak_pkg::BK_OUT : r_state;
                n_state = wsak_pkg::BK_ROUND;
                n_round = '0;
                n_a     = r_h[0];
                n_b     = r_h[1];
                n_c     = r_h[2];
                n_d     = r_h[3];
                n_e     = r_h[4];
            end
        end
    end

endmodule

[design/websocket_accept_key.sv]
// ----------------------------------------------------------------------------
// websocket_accept_key
// WebSocket Sec-WebSocket-Accept generator: SHA-1 of key plus GUID, base64.
// ----------------------------------------------------------------------------
// Key bytes are taken at up to one item per cycle while the internal queue
// has room and no GUID is being inserted. The hash engine takes up to one
// byte per cycle as it gathers a 64-byte block, then runs 80 SHA-1 rounds
// and the chaining add on it. After the last item the front inserts the 36
// GUID bytes (one per cycle while the queue has room) and a finish marker;
// the engine pads the message, runs one or two more blocks and emits up to
// 28 base64 characters, one per cycle while the four-entry queue has room.
// The next key's bytes are accepted meanwhile until the internal queue fills.
module websocket_accept_key #(
    parameter int MAX_MESSAGE_BYTES = wsak_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  wsak_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output wsak_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_wdata
);
    localparam int MIDW = $bits(wsak_pkg::t_mid_item);
    localparam int OUTW = $bits(wsak_pkg::t_out_item);

    logic                mid_push;
    logic                mid_pop;
    logic                mid_full;
    logic                mid_empty;
    wsak_pkg::t_mid_item mid_wdata;
    wsak_pkg::t_mid_item mid_rdata;
    logic                out_push;
    logic                out_full;
    wsak_pkg::t_out_item out_wdata;

    // Front: key filtering and GUID insertion.
    wsak_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_mid_push (mid_push),
        .o_mid_item (mid_wdata),
        .i_mid_full (mid_full)
    );

    // Queue between the front and the hash engine.
    wsak_fifo #(
        .WIDTH (MIDW),
        .DEPTH (wsak_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_wdata (mid_wdata),
        .i_pop   (mid_pop),
        .o_rdata (mid_rdata),
        .o_full  (mid_full),
        .o_empty (mid_empty)
    );

    // Hash engine and encoder.
    wsak_back #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_mid_item  (mid_rdata),
        .i_mid_empty (mid_empty),
        .o_mid_pop   (mid_pop),
        .o_out_push  (out_push),
        .o_out_item  (out_wdata),
        .i_out_full  (out_full)
    );

    // Result queue.
    wsak_fifo #(
        .WIDTH (OUTW),
        .DEPTH (wsak_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_wdata),
        .i_pop   (pop),
        .o_rdata (o_result),
        .o_full  (out_full),
        .o_empty (empty)
    );

endmodule
